// File: rtl/qvc_pkg.sv
// shared types and constants of the quadrilateral validity check
package qvc_pkg;

  // width of one coordinate field on the request channel
  localparam int unsigned FIELD_W = 16;

  // configuration register width and bus geometry
  localparam int unsigned REG_W      = 31;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // reset values of the configuration registers
  localparam logic [REG_W-1:0] MIN_AREA_RST  = REG_W'(100);
  localparam logic [REG_W-1:0] SYM_LIMIT_RST = REG_W'(384);

  // register index, taken from the word address bit
  typedef enum logic {
    REG_MIN_AREA  = 1'b0,
    REG_SYM_LIMIT = 1'b1
  } qvc_reg_e;

  // configuration handed from the register block to the pipeline
  typedef struct packed {
    logic [REG_W-1:0] min_area;
    logic [REG_W-1:0] symmetry_limit;
  } qvc_cfg_t;

endpackage

// File: rtl/qvc_if.sv
// request and result channel interfaces of the quadrilateral validity check

// request channel: four corners of one candidate quad
interface qvc_in_if;
  logic                             valid;
  logic                             ready;
  logic [qvc_pkg::FIELD_W-1:0]      p0_x;
  logic [qvc_pkg::FIELD_W-1:0]      p0_y;
  logic [qvc_pkg::FIELD_W-1:0]      p1_x;
  logic [qvc_pkg::FIELD_W-1:0]      p1_y;
  logic [qvc_pkg::FIELD_W-1:0]      p2_x;
  logic [qvc_pkg::FIELD_W-1:0]      p2_y;
  logic [qvc_pkg::FIELD_W-1:0]      p3_x;
  logic [qvc_pkg::FIELD_W-1:0]      p3_y;

  modport source (
    output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    output ready
  );
endinterface

// result channel: one pass flag per request
interface qvc_out_if;
  logic valid;
  logic ready;
  logic quad_ok;

  modport source (
    output valid, quad_ok,
    input  ready
  );
  modport sink (
    input  valid, quad_ok,
    output ready
  );
endinterface

// File: rtl/qvc_apb_regs.sv
// apb configuration registers: minimum area and symmetry limit
module qvc_apb_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [qvc_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [qvc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [qvc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  output qvc_pkg::qvc_cfg_t                   cfg_o
);

  qvc_pkg::qvc_cfg_t cfg_q, cfg_d;
  qvc_pkg::qvc_reg_e reg_sel;
  logic              wr_en;

  // register select from the word address
  assign reg_sel = qvc_pkg::qvc_reg_e'(paddr[qvc_pkg::APB_ADDR_W-1]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // write decode, low 31 data bits kept
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        qvc_pkg::REG_MIN_AREA:  cfg_d.min_area       = pwdata[qvc_pkg::REG_W-1:0];
        qvc_pkg::REG_SYM_LIMIT: cfg_d.symmetry_limit = pwdata[qvc_pkg::REG_W-1:0];
        default:                cfg_d                = cfg_q;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_area       <= qvc_pkg::MIN_AREA_RST;
      cfg_q.symmetry_limit <= qvc_pkg::SYM_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (reg_sel)
      qvc_pkg::REG_MIN_AREA:  prdata = qvc_pkg::APB_DATA_W'(cfg_q.min_area);
      qvc_pkg::REG_SYM_LIMIT: prdata = qvc_pkg::APB_DATA_W'(cfg_q.symmetry_limit);
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/qvc_pipe.sv
// ten stage pipeline computing the area, winding, sign and symmetry checks
module qvc_pipe #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qvc_pkg::qvc_cfg_t cfg_i,
  qvc_in_if.sink            req_i,
  qvc_out_if.source         rsp_o
);

  localparam int unsigned STAGES  = 10;
  localparam int unsigned DIFF_W  = COORD_BITS + 1;
  localparam int unsigned PRD_W   = 2 * DIFF_W;
  localparam int unsigned CROSS_W = PRD_W + 1;
  localparam int unsigned MAG_W   = CROSS_W - 1;
  localparam int unsigned AREA_W  = (MAG_W > qvc_pkg::REG_W) ? MAG_W : qvc_pkg::REG_W;
  localparam int unsigned SPLIT_W = (MAG_W + 1) / 2;
  localparam int unsigned UPPER_W = MAG_W - SPLIT_W;
  localparam int unsigned PPL_W   = SPLIT_W + qvc_pkg::REG_W;
  localparam int unsigned PPH_W   = UPPER_W + qvc_pkg::REG_W;
  localparam int unsigned CMP_W   = MAG_W + qvc_pkg::REG_W;

  // per stage valid bits and advance chain
  logic [STAGES:1]   vld_q, vld_d;
  logic [STAGES+1:1] adv;

  assign adv[STAGES+1] = rsp_o.ready;

  for (genvar k = 1; k <= STAGES; k++) begin : g_adv
    assign adv[k] = ~vld_q[k] | adv[k+1];
  end

  assign vld_d = (adv[STAGES:1] & {vld_q[STAGES-1:1], req_i.valid})
               | (~adv[STAGES:1] & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign req_i.ready = adv[1];

  // stage 1: sign extend, reorder corners as 0,3,1,2, first edge vectors
  logic signed [DIFF_W-1:0] in_x [4];
  logic signed [DIFF_W-1:0] in_y [4];
  logic signed [DIFF_W-1:0] q_x_s1 [4];
  logic signed [DIFF_W-1:0] q_y_s1 [4];
  logic signed [DIFF_W-1:0] ux_s1, uy_s1, vx_s1, vy_s1;

  always_comb begin
    in_x[0] = DIFF_W'($signed(req_i.p0_x[COORD_BITS-1:0]));
    in_y[0] = DIFF_W'($signed(req_i.p0_y[COORD_BITS-1:0]));
    in_x[1] = DIFF_W'($signed(req_i.p3_x[COORD_BITS-1:0]));
    in_y[1] = DIFF_W'($signed(req_i.p3_y[COORD_BITS-1:0]));
    in_x[2] = DIFF_W'($signed(req_i.p1_x[COORD_BITS-1:0]));
    in_y[2] = DIFF_W'($signed(req_i.p1_y[COORD_BITS-1:0]));
    in_x[3] = DIFF_W'($signed(req_i.p2_x[COORD_BITS-1:0]));
    in_y[3] = DIFF_W'($signed(req_i.p2_y[COORD_BITS-1:0]));
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      q_x_s1 <= in_x;
      q_y_s1 <= in_y;
      ux_s1  <= in_x[1] - in_x[0];
      uy_s1  <= in_y[1] - in_y[0];
      vx_s1  <= in_x[2] - in_x[0];
      vy_s1  <= in_y[2] - in_y[0];
    end
  end

  // stage 2: products of the corner zero cross
  logic signed [DIFF_W-1:0] q_x_s2 [4];
  logic signed [DIFF_W-1:0] q_y_s2 [4];
  logic signed [PRD_W-1:0]  pa_s2, pb_s2;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      q_x_s2 <= q_x_s1;
      q_y_s2 <= q_y_s1;
      pa_s2  <= ux_s1 * vy_s1;
      pb_s2  <= uy_s1 * vx_s1;
    end
  end

  // stage 3: corner zero cross
  logic signed [DIFF_W-1:0]  q_x_s3 [4];
  logic signed [DIFF_W-1:0]  q_y_s3 [4];
  logic signed [CROSS_W-1:0] da_s3;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      q_x_s3 <= q_x_s2;
      q_y_s3 <= q_y_s2;
      da_s3  <= CROSS_W'(pa_s2) - CROSS_W'(pb_s2);
    end
  end

  // stage 4: winding swap, magnitude of the anchor area, remaining edge vectors
  logic                      swap;
  logic signed [CROSS_W-1:0] da_abs;
  logic signed [DIFF_W-1:0]  r_x [4];
  logic signed [DIFF_W-1:0]  r_y [4];
  logic signed [DIFF_W-1:0]  ux_s4 [3];
  logic signed [DIFF_W-1:0]  uy_s4 [3];
  logic signed [DIFF_W-1:0]  vx_s4 [3];
  logic signed [DIFF_W-1:0]  vy_s4 [3];
  logic [MAG_W-1:0]          ma_s4;
  logic                      dz_s4;

  always_comb begin
    swap   = !da_s3[CROSS_W-1] && (da_s3 != '0);
    da_abs = da_s3[CROSS_W-1] ? -da_s3 : da_s3;
    r_x[0] = q_x_s3[0];
    r_y[0] = q_y_s3[0];
    r_x[1] = swap ? q_x_s3[2] : q_x_s3[1];
    r_y[1] = swap ? q_y_s3[2] : q_y_s3[1];
    r_x[2] = swap ? q_x_s3[1] : q_x_s3[2];
    r_y[2] = swap ? q_y_s3[1] : q_y_s3[2];
    r_x[3] = q_x_s3[3];
    r_y[3] = q_y_s3[3];
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      // cross at the last corner
      ux_s4[0] <= r_x[2] - r_x[3];
      uy_s4[0] <= r_y[2] - r_y[3];
      vx_s4[0] <= r_x[1] - r_x[3];
      vy_s4[0] <= r_y[1] - r_y[3];
      // cross at the third corner
      ux_s4[1] <= r_x[3] - r_x[2];
      uy_s4[1] <= r_y[3] - r_y[2];
      vx_s4[1] <= r_x[0] - r_x[2];
      vy_s4[1] <= r_y[0] - r_y[2];
      // cross at the second corner
      ux_s4[2] <= r_x[0] - r_x[1];
      uy_s4[2] <= r_y[0] - r_y[1];
      vx_s4[2] <= r_x[3] - r_x[1];
      vy_s4[2] <= r_y[3] - r_y[1];
      ma_s4    <= da_abs[MAG_W-1:0];
      dz_s4    <= (da_s3 == '0);
    end
  end

  // stage 5: remaining cross products, area test
  logic signed [PRD_W-1:0] p1_s5 [3];
  logic signed [PRD_W-1:0] p2_s5 [3];
  logic [MAG_W-1:0]        ma_s5;
  logic                    dz_s5;
  logic                    area_ok_s5;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      for (int j = 0; j < 3; j++) begin
        p1_s5[j] <= ux_s4[j] * vy_s4[j];
        p2_s5[j] <= uy_s4[j] * vx_s4[j];
      end
      ma_s5      <= ma_s4;
      dz_s5      <= dz_s4;
      area_ok_s5 <= AREA_W'(ma_s4) >= AREA_W'(cfg_i.min_area);
    end
  end

  // stage 6: remaining crosses
  logic signed [CROSS_W-1:0] cr_s6 [3];
  logic [MAG_W-1:0]          ma_s6;
  logic                      dz_s6;
  logic                      area_ok_s6;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      for (int j = 0; j < 3; j++) begin
        cr_s6[j] <= CROSS_W'(p1_s5[j]) - CROSS_W'(p2_s5[j]);
      end
      ma_s6      <= ma_s5;
      dz_s6      <= dz_s5;
      area_ok_s6 <= area_ok_s5;
    end
  end

  // stage 7: sign agreement, magnitude of the opposite area
  logic                      sign_ab, sign_cd;
  logic signed [CROSS_W-1:0] db_abs;
  logic [MAG_W-1:0]          ma_s7, mb_s7;
  logic                      ok_s7;

  always_comb begin
    sign_ab = dz_s6 ? (cr_s6[0] == '0) : cr_s6[0][CROSS_W-1];
    sign_cd = (cr_s6[1][CROSS_W-1] == cr_s6[2][CROSS_W-1])
           && ((cr_s6[1] == '0) == (cr_s6[2] == '0));
    db_abs  = cr_s6[0][CROSS_W-1] ? -cr_s6[0] : cr_s6[0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      ma_s7 <= ma_s6;
      mb_s7 <= db_abs[MAG_W-1:0];
      ok_s7 <= area_ok_s6 && sign_ab && sign_cd;
    end
  end

  // stage 8: larger and smaller area
  logic [MAG_W-1:0] hi_s8, lo_s8;
  logic             ok_s8;

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      hi_s8 <= (ma_s7 > mb_s7) ? ma_s7 : mb_s7;
      lo_s8 <= (ma_s7 > mb_s7) ? mb_s7 : ma_s7;
      ok_s8 <= ok_s7;
    end
  end

  // stage 9: smaller area times limit as two partial products
  logic [PPL_W-1:0] ppl_s9;
  logic [PPH_W-1:0] pph_s9;
  logic [CMP_W-1:0] hi_sh_s9;
  logic             ok_s9;

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      ppl_s9   <= PPL_W'(lo_s8[SPLIT_W-1:0]) * PPL_W'(cfg_i.symmetry_limit);
      pph_s9   <= PPH_W'(lo_s8[MAG_W-1:SPLIT_W]) * PPH_W'(cfg_i.symmetry_limit);
      hi_sh_s9 <= CMP_W'(hi_s8) << FRAC_BITS;
      ok_s9    <= ok_s8;
    end
  end

  // stage 10: symmetry compare into the output register
  logic [CMP_W-1:0] lo_prod;
  logic             quad_ok_q;

  assign lo_prod = (CMP_W'(pph_s9) << SPLIT_W) + CMP_W'(ppl_s9);

  always_ff @(posedge clk_i) begin
    if (adv[10]) begin
      quad_ok_q <= ok_s9 && (hi_sh_s9 < lo_prod);
    end
  end

  assign rsp_o.valid   = vld_q[STAGES];
  assign rsp_o.quad_ok = quad_ok_q;

  // no request is refused while a bubble sits in the pipeline
  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (&vld_q))
    else $error("request refused with a free stage");

  // an accepted request always lands in stage one
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> vld_q[1])
    else $error("accepted request lost at stage one");

  // zero flag of the anchor area agrees with its magnitude
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> ((ma_s5 == '0) == dz_s5))
    else $error("anchor zero flag out of step with magnitude");

  // larger area never below smaller area
  a_hi_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] |-> (hi_s8 >= lo_s8))
    else $error("area ordering broken");

endmodule

// File: rtl/quadrilateral_validity_check_unit.sv
// quadrilateral validity check: top level with config port and pipeline
//
// Usage
//   req_i carries one candidate quad per request: four corners p0..p3, each
//   a signed x,y pair. rsp_o returns one quad_ok flag per request, in order.
//   Both channels use valid/ready; a request moves when both are high.
//   The APB port sets min_area (0x0) and symmetry_limit (0x4), 31 bits each;
//   write them only while no request is in flight.
// Pipeline
//   Ten register stages; a result shows on rsp_o once its request has
//   passed them all. One request enters per cycle while req_i.ready is
//   high; the two-multiplier stages for the anchor cross and the six
//   products of the other crosses set the depth.
// Reset
//   rst_ni clears every stage valid bit and loads min_area = 100 and
//   symmetry_limit = 384 (1.5 with 8 fraction bits).
// Stalls
//   When rsp_o.ready is low, the output stage holds its flag and earlier
//   stages keep filling empty slots; req_i.ready drops only once all ten
//   stages hold a request.
module quadrilateral_validity_check_unit #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [qvc_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [qvc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [qvc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  qvc_in_if.sink                              req_i,
  qvc_out_if.source                           rsp_o
);

  qvc_pkg::qvc_cfg_t cfg;

  // configuration registers
  qvc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // check pipeline
  qvc_pipe #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule
